/* src/wftp_pkg.sv */
// ----------------------------------------------------------------------------
// wftp_pkg
// Shared types, codes and the nice-to-weight table of the task picker.
// ----------------------------------------------------------------------------
package wftp_pkg;

    // operation codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_PICK  = 2'd1;
    localparam logic [1:0] FUNC_WAKE  = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // task state codes
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;

    localparam logic [5:0]  NICE_MAX    = 6'd39;
    localparam logic [19:0] WAKE_CREDIT = 20'd1024000;
    localparam logic [15:0] SLICE_RESET = 16'd10000;

    // weight of a nice level; above the maximum is clamped
    function automatic logic [16:0] weight_of(input logic [5:0] n);
        logic [16:0] w;
        begin
            unique case (n)
                6'd0:  w = 17'd88761; 6'd1:  w = 17'd71755; 6'd2:  w = 17'd56483;
                6'd3:  w = 17'd46273; 6'd4:  w = 17'd36291; 6'd5:  w = 17'd29154;
                6'd6:  w = 17'd23254; 6'd7:  w = 17'd18705; 6'd8:  w = 17'd14949;
                6'd9:  w = 17'd11916; 6'd10: w = 17'd9548;  6'd11: w = 17'd7620;
                6'd12: w = 17'd6100;  6'd13: w = 17'd4904;  6'd14: w = 17'd3906;
                6'd15: w = 17'd3121;  6'd16: w = 17'd2501;  6'd17: w = 17'd1991;
                6'd18: w = 17'd1586;  6'd19: w = 17'd1277;  6'd20: w = 17'd1024;
                6'd21: w = 17'd820;   6'd22: w = 17'd655;   6'd23: w = 17'd526;
                6'd24: w = 17'd423;   6'd25: w = 17'd335;   6'd26: w = 17'd272;
                6'd27: w = 17'd215;   6'd28: w = 17'd172;   6'd29: w = 17'd137;
                6'd30: w = 17'd110;   6'd31: w = 17'd87;    6'd32: w = 17'd70;
                6'd33: w = 17'd56;    6'd34: w = 17'd45;    6'd35: w = 17'd36;
                6'd36: w = 17'd29;    6'd37: w = 17'd23;    6'd38: w = 17'd18;
                default: w = 17'd15;
            endcase
            return w;
        end
    endfunction

    // wake credit 1024000 / weight, precomputed per nice level
    function automatic logic [16:0] credit_of(input logic [5:0] n);
        logic [16:0] c;
        begin
            unique case (n)
                6'd0:  c = 17'd11;    6'd1:  c = 17'd14;    6'd2:  c = 17'd18;
                6'd3:  c = 17'd22;    6'd4:  c = 17'd28;    6'd5:  c = 17'd35;
                6'd6:  c = 17'd44;    6'd7:  c = 17'd54;    6'd8:  c = 17'd68;
                6'd9:  c = 17'd85;    6'd10: c = 17'd107;   6'd11: c = 17'd134;
                6'd12: c = 17'd167;   6'd13: c = 17'd208;   6'd14: c = 17'd262;
                6'd15: c = 17'd328;   6'd16: c = 17'd409;   6'd17: c = 17'd514;
                6'd18: c = 17'd645;   6'd19: c = 17'd801;   6'd20: c = 17'd1000;
                6'd21: c = 17'd1248;  6'd22: c = 17'd1563;  6'd23: c = 17'd1946;
                6'd24: c = 17'd2420;  6'd25: c = 17'd3056;  6'd26: c = 17'd3764;
                6'd27: c = 17'd4762;  6'd28: c = 17'd5953;  6'd29: c = 17'd7474;
                6'd30: c = 17'd9309;  6'd31: c = 17'd11770; 6'd32: c = 17'd14628;
                6'd33: c = 17'd18285; 6'd34: c = 17'd22755; 6'd35: c = 17'd28444;
                6'd36: c = 17'd35310; 6'd37: c = 17'd44521; 6'd38: c = 17'd56888;
                default: c = 17'd68266;
            endcase
            return c;
        end
    endfunction

endpackage

/* src/weighted_fair_task_picker_core.sv */
// ----------------------------------------------------------------------------
// weighted_fair_task_picker_core
// Task table with minimum virtual runtime pick and channel wake.
// ----------------------------------------------------------------------------
// One transaction at a time. A write or a read goes through the read state
// and then the done state. Pick scans the table memory one entry a cycle,
// then runs 33 divider steps and writes the chosen state back. Wake makes
// two scans, the second as a read-modify-write pass. The one-entry-a-cycle
// scan of the table memory sets the rate. The result sits in an output
// register; the next transaction is taken the cycle after that register
// is emptied.
module weighted_fair_task_picker_core import wftp_pkg::*; #(
    parameter int NUM_TASKS    = 64,
    parameter int CHANNEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [5:0]  i_entry_index,
    input  logic [2:0]  i_task_state,
    input  logic [5:0]  i_nice_level,
    input  logic [31:0] i_virtual_runtime,
    input  logic [15:0] i_wait_channel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [5:0]  o_chosen_index,
    output logic [2:0]  o_out_state,
    output logic [5:0]  o_out_nice,
    output logic [31:0] o_out_vruntime,
    output logic [15:0] o_quantum,
    output logic [6:0]  o_woken_count
);

    localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = AW + 1;

    // states of the sequencer
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WAKE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    typedef struct packed {
        logic [2:0]              st;
        logic [5:0]              nice;
        logic [31:0]             vr;
        logic [CHANNEL_BITS-1:0] ch;
    } t_entry;

    // state array with valid bits (reset to unused); rest in memory
    t_entry          mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_written;
    t_entry          r_rdata;
    logic            r_rd_wr;

    logic [2:0]  r_fsm;
    logic [15:0] r_slice;
    logic [1:0]  r_func;
    logic [5:0]  r_idx_in;
    logic [2:0]  r_st_in;
    logic [5:0]  r_nice_in;
    logic [31:0] r_vr_in;
    logic [CHANNEL_BITS-1:0] r_ch;

    logic [CW-1:0] r_addr;      // address issued
    logic [CW-1:0] r_seen;      // address of data in r_rdata
    logic          r_seen_vld;
    logic          r_pass2;
    logic          r_found;
    logic [AW-1:0] r_best;
    logic [31:0]   r_bestv;
    logic [16:0]   r_bestw;
    logic [22:0]   r_sum;
    logic [6:0]    r_count;

    logic        r_oval, r_ok;
    logic [5:0]  r_oidx, r_onice;
    logic [2:0]  r_ost;
    logic [31:0] r_ovr;
    logic [15:0] r_oslice;
    logic [6:0]  r_ocnt;

    logic        w_accept, w_in_range, w_div_start, w_div_done;
    logic        w_rd_hit;
    logic [15:0] w_quo;
    logic [32:0] w_prod;
    logic [2:0]  w_rst;
    logic        w_runnable;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    t_entry      w_wdata;

    assign o_ready  = (r_fsm == S_IDLE) && !r_oval;
    assign w_accept = i_valid && o_ready;
    assign w_in_range = (32'(r_idx_in) < 32'(NUM_TASKS));
    assign w_rd_hit   = (r_func == FUNC_READ) && w_in_range;

    // state of the entry just read, unused if never written
    assign w_rst      = r_written[r_seen[AW-1:0]] ? r_rdata.st : 3'd0;
    assign w_runnable = r_seen_vld && (w_rst == ST_RUNNABLE);

    // product of slice and chosen weight, 16 x 17 bits
    assign w_prod = 33'(r_slice) * 33'(r_bestw);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= SLICE_RESET;
        end else if (i_cfg_we) begin
            r_slice <= i_cfg_wdata;
        end
    end

    // write port selection for the table memory
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(r_idx_in);
        w_wdata = '{st: r_st_in, nice: r_nice_in, vr: r_vr_in, ch: r_ch};
        if (r_fsm == S_RD && r_func == FUNC_WRITE && r_nice_in <= NICE_MAX
            && w_in_range) begin
            w_we = 1'b1;
        end else if (r_fsm == S_DIV && w_div_done) begin
            w_we    = 1'b1;
            w_waddr = r_best;
            w_wdata = r_rdata;
            w_wdata.st = ST_RUNNING;
        end else if (r_fsm == S_WAKE && r_pass2 && r_seen_vld
                     && w_rst == ST_SLEEPING && r_rdata.ch == r_ch) begin
            w_we       = 1'b1;
            w_waddr    = r_seen[AW-1:0];
            w_wdata    = r_rdata;
            w_wdata.st = ST_RUNNABLE;
            w_wdata.vr = r_found ? (r_bestv - 32'(credit_of(r_rdata.nice))) : '0;
        end
    end

    // table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (w_we) begin
            r_written[w_waddr] <= 1'b1;
        end
    end

    assign w_div_start = (r_fsm == S_SCAN) && !r_seen_vld && r_addr == CW'(NUM_TASKS)
                         && r_rd_wr && r_found;

    wftp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  ({1'b0, r_sum}),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_oval     <= 1'b0;
            r_seen_vld <= 1'b0;
            r_rd_wr    <= 1'b0;
        end else begin
            if (r_oval && i_ready) r_oval <= 1'b0;
            unique case (r_fsm)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func    <= i_func;
                        r_idx_in  <= i_entry_index;
                        r_st_in   <= i_task_state;
                        r_nice_in <= i_nice_level;
                        r_vr_in   <= i_virtual_runtime;
                        r_ch      <= CHANNEL_BITS'(i_wait_channel);
                        r_addr    <= (i_func == FUNC_READ) ? CW'(i_entry_index)
                                                           : '0;
                        r_seen_vld <= 1'b0;
                        r_rd_wr   <= 1'b0;
                        r_pass2   <= 1'b0;
                        r_found   <= 1'b0;
                        r_sum     <= '0;
                        r_count   <= '0;
                        r_fsm     <= (i_func == FUNC_WRITE || i_func == FUNC_READ)
                                     ? S_RD
                                     : ((i_func == FUNC_PICK) ? S_SCAN : S_WAKE);
                    end
                end
                S_RD: begin
                    // read data arrives in the cycle after the address
                    r_rd_wr <= 1'b1;
                    r_seen  <= r_addr;
                    if (r_rd_wr || r_func == FUNC_WRITE) begin
                        r_ok     <= w_in_range && (r_func == FUNC_READ
                                                   || r_nice_in <= NICE_MAX);
                        r_oidx   <= w_rd_hit ? r_idx_in : '0;
                        r_ost    <= w_rd_hit ? w_rst : '0;
                        r_onice  <= w_rd_hit ? r_rdata.nice : '0;
                        r_ovr    <= w_rd_hit ? r_rdata.vr : '0;
                        r_oslice <= '0;
                        r_ocnt   <= '0;
                        r_fsm    <= S_DONE;
                    end
                end
                S_SCAN, S_WAKE: begin
                    // stream addresses; process returning entries
                    r_seen     <= r_addr;
                    r_seen_vld <= (r_addr < CW'(NUM_TASKS));
                    if (r_addr < CW'(NUM_TASKS)) r_addr <= r_addr + CW'(1);
                    if (!r_pass2 && w_runnable
                        && (!r_found || r_rdata.vr < r_bestv)) begin
                        r_found <= 1'b1;
                        r_best  <= r_seen[AW-1:0];
                        r_bestv <= r_rdata.vr;
                        r_bestw <= weight_of(r_rdata.nice);
                    end
                    if (w_runnable && r_fsm == S_SCAN)
                        r_sum <= r_sum + 23'(weight_of(r_rdata.nice));
                    if (w_we && r_fsm == S_WAKE) r_count <= r_count + 7'd1;
                    if (r_addr == CW'(NUM_TASKS) && !r_seen_vld) begin
                        if (!r_rd_wr) begin
                            r_rd_wr <= 1'b1;   // wait for last result
                        end else if (r_fsm == S_WAKE && !r_pass2) begin
                            r_pass2 <= 1'b1;
                            r_addr  <= '0;
                            r_rd_wr <= 1'b0;
                        end else if (r_fsm == S_WAKE) begin
                            r_ok <= 1'b1; r_oidx <= '0; r_ost <= '0;
                            r_onice <= '0; r_ovr <= '0; r_oslice <= '0;
                            r_ocnt <= r_count;
                            r_fsm <= S_DONE;
                        end else if (r_found) begin
                            r_addr <= CW'(r_best);   // reread chosen entry
                            r_fsm  <= S_DIV;
                        end else begin
                            r_ok <= 1'b0; r_oidx <= '0; r_ost <= '0;
                            r_onice <= '0; r_ovr <= '0; r_oslice <= '0;
                            r_ocnt <= '0;
                            r_fsm <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_ok     <= 1'b1;
                        r_oidx   <= 6'(r_best);
                        r_ost    <= '0;
                        r_onice  <= '0;
                        r_ovr    <= r_bestv;
                        r_oslice <= w_quo;
                        r_ocnt   <= '0;
                        r_fsm    <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_oval <= 1'b1;
                    r_fsm  <= S_IDLE;
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_oval;
    assign o_ok           = r_ok;
    assign o_chosen_index = r_oidx;
    assign o_out_state    = r_ost;
    assign o_out_nice     = r_onice;
    assign o_out_vruntime = r_ovr;
    assign o_quantum      = r_oslice;
    assign o_woken_count  = r_ocnt;

endmodule

/* src/wftp_divider.sv */
// ----------------------------------------------------------------------------
// wftp_divider
// Restoring divider, one quotient bit per cycle, for the pick time slice.
// ----------------------------------------------------------------------------
module wftp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [23:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    logic [32:0] r_quo, n_quo;
    logic [23:0] r_rem, n_rem;
    logic [23:0] r_div;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [24:0] w_trial;

    // one shift-subtract step; the remainder stays below the divisor
    always_comb begin
        w_trial = {r_rem, r_quo[32]};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = 6'd33;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = 24'(w_trial - {1'b0, r_div});
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = w_trial[23:0];
                n_quo = {r_quo[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        if (i_start) r_div <= i_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[15:0];

endmodule
